[sv/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, round constants, initial hash values and SHA-256 helper
// functions for the hash engine.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int BlockWords  = 16;
    localparam int Rounds      = 64;
    localparam int DigestWords = 8;
    localparam int LenBytes    = 8;
    localparam int LastDataPos = 55;

    typedef logic [31:0] t_word;

    localparam logic [7:0] PadByte = 8'h80;

    localparam t_word K_TABLE [0:Rounds-1] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word IV [0:DigestWords-1] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_UPDATE,
        S_PAD_FIRST,
        S_PAD_LEN,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        POST_IDLE,
        POST_PAD_FIRST,
        POST_PAD_LEN,
        POST_EMIT
    } t_post;

    typedef struct packed {
        logic        wr_byte;
        logic [7:0]  byte_val;
        logic [5:0]  pos;
        logic        pad_first;
        logic        pad_len;
        logic        len_in_first;
        logic [63:0] bit_count;
        logic        round_en;
        logic [5:0]  round;
    } t_msg_ctl;

    typedef struct packed {
        logic       start;
        logic       round_en;
        logic [5:0] round;
        logic       update;
        logic       restart;
        logic [2:0] rd_idx;
    } t_core_ctl;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

[sv/sha_msg.sv]
// ----------------------------------------------------------------------------
// sha_msg
// Block buffer with byte writes and padding, and the rolling message
// schedule window that supplies one word per round.
// ----------------------------------------------------------------------------
module sha_msg (
    input  logic              i_clk,
    input  sha_pkg::t_msg_ctl i_ctl,
    output sha_pkg::t_word    o_w
);
    import sha_pkg::*;

    t_word r_buf   [0:BlockWords-1];
    t_word n_buf   [0:BlockWords-1];
    t_word r_sched [0:BlockWords-1];

    always_comb begin
        logic [5:0] jj;
        logic       len_en;
        len_en = i_ctl.pad_len || (i_ctl.pad_first && i_ctl.len_in_first);
        for (int w = 0; w < BlockWords; w++) begin
            n_buf[w] = r_buf[w];
            for (int l = 0; l < 4; l++) begin
                jj = 6'(w * 4 + l);
                if (i_ctl.wr_byte && jj == i_ctl.pos) begin
                    n_buf[w][31 - 8 * l -: 8] = i_ctl.byte_val;
                end
                if (i_ctl.pad_first) begin
                    if (jj == i_ctl.pos) begin
                        n_buf[w][31 - 8 * l -: 8] = PadByte;
                    end else if (jj > i_ctl.pos) begin
                        n_buf[w][31 - 8 * l -: 8] = 8'h00;
                    end
                end
                if (i_ctl.pad_len) begin
                    n_buf[w][31 - 8 * l -: 8] = 8'h00;
                end
            end
        end
        if (len_en) begin
            for (int k = 0; k < LenBytes; k++) begin
                n_buf[BlockWords - 2 + k / 4][31 - 8 * (k % 4) -: 8] =
                    i_ctl.bit_count[63 - 8 * k -: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    always_comb begin
        if (i_ctl.round < 6'(BlockWords)) begin
            o_w = r_buf[i_ctl.round[3:0]];
        end else begin
            o_w = small_sigma1(r_sched[14]) + r_sched[9]
                + small_sigma0(r_sched[1]) + r_sched[0];
        end
    end

    // window holds the last sixteen schedule words, oldest first
    always_ff @(posedge i_clk) begin
        if (i_ctl.round_en) begin
            for (int i = 0; i < BlockWords - 1; i++) begin
                r_sched[i] <= r_sched[i + 1];
            end
            r_sched[BlockWords - 1] <= o_w;
        end
    end

endmodule

[sv/sha_core.sv]
// ----------------------------------------------------------------------------
// sha_core
// Hash state and working variables with the shared compression round,
// applied once per cycle under the sequencer.
// ----------------------------------------------------------------------------
module sha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha_pkg::t_core_ctl i_ctl,
    input  sha_pkg::t_word     i_w,
    output sha_pkg::t_word     o_digest
);
    import sha_pkg::*;

    t_word r_hash [0:DigestWords-1];
    t_word r_v    [0:DigestWords-1];
    t_word t1;
    t_word t2;

    always_comb begin
        t1 = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + K_TABLE[i_ctl.round] + i_w;
        t2 = big_sigma0(r_v[0])
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_v <= r_hash;
        end else if (i_ctl.round_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= IV;
        end else if (i_ctl.restart) begin
            r_hash <= IV;
        end else if (i_ctl.update) begin
            for (int i = 0; i < DigestWords; i++) begin
                r_hash[i] <= r_hash[i] + r_v[i];
            end
        end
    end

    assign o_digest = r_hash[i_ctl.rd_idx];

endmodule

[sv/sha256_hash_engine.sv]
// ----------------------------------------------------------------------------
// sha256_hash_engine
// SHA-256 over a byte stream with padding and digest output.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one request carries an optional byte
// and an end-of-message flag. A request that neither fills a block nor
// ends the message is taken without a stall, so o_stall stays low.
// A request whose byte completes a 64-byte block starts a compression:
// the compression rounds, then one hash update, during which o_stall is
// high. The rounds run one per cycle on the shared round unit.
// An ending request pads the buffer, runs one or two more compressions,
// then presents eight digest words on the output channel (o_valid /
// i_stall), word 0 first, o_last_word on word 7.
// Each word holds while i_stall is high; o_stall stays high until word 7
// is taken, then the hash returns to its initial value.
// Reset (synchronous, active low) loads the initial hash, clears the byte
// position and bit count, and returns to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha256_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha_pkg::*;

    t_state      r_state, n_state;
    t_post       r_post, n_post;
    logic [5:0]  r_pos, n_pos;
    logic [63:0] r_count, n_count;
    logic [5:0]  r_round, n_round;
    logic [2:0]  r_idx, n_idx;

    t_msg_ctl    msg_ctl;
    t_core_ctl   core_ctl;
    t_word       sched_w;
    t_word       digest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_post  <= POST_IDLE;
            r_pos   <= '0;
            r_count <= '0;
            r_round <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_post  <= n_post;
            r_pos   <= n_pos;
            r_count <= n_count;
            r_round <= n_round;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_post   = r_post;
        n_pos    = r_pos;
        n_count  = r_count;
        n_round  = r_round;
        n_idx    = r_idx;
        msg_ctl  = '0;
        core_ctl = '0;
        msg_ctl.pos       = r_pos;
        msg_ctl.byte_val  = i_data_byte;
        msg_ctl.bit_count = r_count;
        msg_ctl.round     = r_round;
        core_ctl.round    = r_round;
        core_ctl.rd_idx   = r_idx;
        o_stall = (r_state != S_IDLE);
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_has_byte) begin
                        msg_ctl.wr_byte = 1'b1;
                        n_count = r_count + 64'd8;
                        n_pos   = r_pos + 6'd1;
                    end
                    if (i_has_byte && r_pos == 6'(BlockWords * 4 - 1)) begin
                        core_ctl.start = 1'b1;
                        n_round = '0;
                        n_state = S_ROUND;
                        n_post  = i_end_of_message ? POST_PAD_FIRST : POST_IDLE;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD_FIRST;
                    end
                end
            end
            S_PAD_FIRST: begin
                msg_ctl.pad_first    = 1'b1;
                msg_ctl.len_in_first = (r_pos <= 6'(LastDataPos));
                core_ctl.start = 1'b1;
                n_round = '0;
                n_state = S_ROUND;
                n_post  = (r_pos <= 6'(LastDataPos)) ? POST_EMIT : POST_PAD_LEN;
            end
            S_PAD_LEN: begin
                msg_ctl.pad_len = 1'b1;
                core_ctl.start  = 1'b1;
                n_round = '0;
                n_state = S_ROUND;
                n_post  = POST_EMIT;
            end
            S_ROUND: begin
                msg_ctl.round_en  = 1'b1;
                core_ctl.round_en = 1'b1;
                n_round = r_round + 6'd1;
                if (r_round == 6'(Rounds - 1)) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                core_ctl.update = 1'b1;
                case (r_post)
                    POST_IDLE:      n_state = S_IDLE;
                    POST_PAD_FIRST: n_state = S_PAD_FIRST;
                    POST_PAD_LEN:   n_state = S_PAD_LEN;
                    POST_EMIT: begin
                        n_state = S_EMIT;
                        n_idx   = '0;
                    end
                    default:        n_state = S_IDLE;
                endcase
            end
            S_EMIT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'(DigestWords - 1)) begin
                        core_ctl.restart = 1'b1;
                        n_pos   = '0;
                        n_count = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    sha_msg u_msg (
        .i_clk (i_clk),
        .i_ctl (msg_ctl),
        .o_w   (sched_w)
    );

    sha_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (core_ctl),
        .i_w      (sched_w),
        .o_digest (digest)
    );

    assign o_digest_word = digest;
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 3'(DigestWords - 1));

`ifndef SYNTHESIS
    a_no_input_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while digest is out");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_word) |=> (!o_valid && !o_stall))
        else $error("engine not idle after last digest word");

    a_end_starts_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_end_of_message
         && !(i_has_byte && r_pos == 6'(BlockWords * 4 - 1)))
        |=> (r_state == S_PAD_FIRST))
        else $error("end of message did not start padding");

    a_stall_during_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (o_stall && !o_valid))
        else $error("channel active during compression");
`endif

endmodule

[tb/sha256_digest_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches the request and digest channels of the hash engine. Every
// accepted request updates a local SHA-256 model of the byte stream. An
// ending request queues the eight digest words it must produce. Each
// accepted digest word is compared with the oldest queued word. The
// failure count and the number of words still owed go to the testbench top.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_stall,
    input  logic [31:0] i_digest_word,
    input  logic [2:0]  i_word_index,
    input  logic        i_last_word,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        sha_pkg::t_word word;
        logic [2:0]     index;
        logic           last;
    } digest_entry_t;

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_HASH [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    logic [31:0]   hash_st [0:7];
    logic [7:0]    blk [0:63];
    logic [5:0]    fill;
    logic [63:0]   bit_total;
    digest_entry_t digest_q [$];
    int            fails = 0;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) hash_st[i] = START_HASH[i];
        fill      = '0;
        bit_total = '0;
    endtask

    task automatic mix_block();
        logic [31:0] w [0:63];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        for (int r = 16; r < 64; r++) begin
            s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
            s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
            w[r] = w[r-16] + s0 + w[r-7] + s1;
        end
        a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3];
        e = hash_st[4]; f = hash_st[5]; g = hash_st[6]; h = hash_st[7];
        for (int r = 0; r < 64; r++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) +
                 ((e & f) ^ (~e & g)) + ROUND_K[r] + w[r];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) +
                 ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
        hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
    endtask

    task automatic place_length();
        for (int i = 0; i < 8; i++) blk[63-i] = bit_total[8*i +: 8];
    endtask

    task automatic absorb_request(input logic [7:0] data, input logic has,
                                  input logic eom);
        int p;
        digest_entry_t ent;
        if (has) begin
            blk[fill] = data;
            bit_total += 64'd8;
            if (fill == 6'd63) begin
                mix_block();
                fill = '0;
            end else begin
                fill = fill + 6'd1;
            end
        end
        if (eom) begin
            p = fill;
            blk[p] = PAD_MARK;
            for (int i = p + 1; i < 64; i++) blk[i] = 8'h00;
            // no room for the length after the mark: spill into a second block
            if (p <= 55) begin
                place_length();
                mix_block();
            end else begin
                mix_block();
                for (int i = 0; i < 64; i++) blk[i] = 8'h00;
                place_length();
                mix_block();
            end
            for (int i = 0; i < 8; i++) begin
                ent.word  = hash_st[i];
                ent.index = 3'(i);
                ent.last  = (i == 7);
                digest_q.push_back(ent);
            end
            restart_hash();
        end
    endtask

    always @(posedge i_clk) begin
        digest_entry_t want;
        if (!i_rst_n) begin
            restart_hash();
            digest_q.delete();
        end else begin
            if (i_req_valid && !i_req_stall)
                absorb_request(i_data_byte, i_has_byte, i_end_of_message);
            if (i_rsp_valid && !i_rsp_stall) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected digest word %h at word_index %0d",
                           i_digest_word, i_word_index);
                    fails++;
                end else begin
                    want = digest_q.pop_front();
                    if (i_digest_word !== want.word) begin
                        $error("digest_word mismatch: expected %h, actual %h",
                               want.word, i_digest_word);
                        fails++;
                    end
                    if (i_word_index !== want.index) begin
                        $error("word_index mismatch: expected %0d, actual %0d",
                               want.index, i_word_index);
                        fails++;
                    end
                    if (i_last_word !== want.last) begin
                        $error("last_word mismatch: expected %0d, actual %0d",
                               want.last, i_last_word);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= digest_q.size();
    end

endmodule

[tb/tb_sha256_hash_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_hash_engine
// Drives byte-stream requests into the hash engine and takes its digest
// words with random gaps and stalls. A short directed part covers empty
// messages, a byte together with the end flag, requests that carry
// nothing, and extreme byte values. Random messages follow, among them
// lengths at the padding and block boundaries. The checker beside the
// engine predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_sha256_hash_engine;

    localparam int RUN_LIMIT     = 400000;
    localparam int RANDOM_ITEMS  = 280;
    localparam int LONG_HOLD     = 500;
    localparam int HOLD_AT_WORD  = 40;
    localparam int DRAIN_CYCLES  = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [7:0]  req_data = 8'h00;
    logic        req_has = 1'b0;
    logic        req_eom = 1'b0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b1;
    logic [31:0] rsp_word;
    logic [2:0]  rsp_index;
    logic        rsp_last;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int counted = 0;
    bit quiet = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sha256_hash_engine dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (req_valid),
        .o_stall          (req_stall),
        .i_data_byte      (req_data),
        .i_has_byte       (req_has),
        .i_end_of_message (req_eom),
        .o_valid          (rsp_valid),
        .i_stall          (rsp_stall),
        .o_digest_word    (rsp_word),
        .o_word_index     (rsp_index),
        .o_last_word      (rsp_last)
    );

    sha256_digest_checker checker_inst (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_req_valid      (req_valid),
        .i_req_stall      (req_stall),
        .i_data_byte      (req_data),
        .i_has_byte       (req_has),
        .i_end_of_message (req_eom),
        .i_rsp_valid      (rsp_valid),
        .i_rsp_stall      (rsp_stall),
        .i_digest_word    (rsp_word),
        .i_word_index     (rsp_index),
        .i_last_word      (rsp_last),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic offer_request(input logic [7:0] data, input logic has,
                                 input logic eom);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= data;
        req_has   <= has;
        req_eom   <= eom;
        do @(posedge clk); while (req_stall);
        counted++;
    endtask

    task automatic wait_all_digests();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic send_message(input int len, input bit separate_end);
        logic [7:0] b;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 7) == 0) offer_request(8'($urandom), 1'b0, 1'b0);
            if ($urandom_range(0, 9) == 0)
                b = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
            else
                b = 8'($urandom);
            offer_request(b, 1'b1, (k == len - 1) && !separate_end);
        end
        if (len == 0 || separate_end) offer_request(8'($urandom), 1'b0, 1'b1);
    endtask

    // digest receiver: random stall per word, one long hold-off
    initial begin
        int hold;
        int taken;
        taken = 0;
        wait (rst_n === 1'b1);
        forever begin
            if (taken == HOLD_AT_WORD) begin
                rsp_stall <= 1'b1;
                do @(posedge clk); while (!rsp_valid);
                hold = LONG_HOLD;
            end else begin
                hold = quiet ? 0 : $urandom_range(0, 13);
            end
            if (hold > 0) begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
            taken++;
        end
    end

    initial begin
        int len;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing, then empty message
        offer_request(8'hff, 1'b0, 1'b0);
        offer_request(8'h00, 1'b0, 1'b1);
        // byte and end together
        offer_request(8'hff, 1'b1, 1'b1);
        // idle request inside a message, end on its own
        offer_request(8'h00, 1'b1, 1'b0);
        offer_request(8'ha5, 1'b0, 1'b0);
        offer_request(8'hff, 1'b1, 1'b0);
        offer_request(8'h5a, 1'b0, 1'b1);
        wait_all_digests();
        offer_request(8'h80, 1'b1, 1'b0);
        offer_request(8'h7f, 1'b1, 1'b0);
        offer_request(8'h01, 1'b1, 1'b1);

        counted = 0;
        // one and two padding blocks, full block before the end
        send_message(55, 1'($urandom_range(0, 1)));
        send_message(56, 1'($urandom_range(0, 1)));
        send_message(64, 1'($urandom_range(0, 1)));
        while (counted < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0)
                len = $urandom_range(13, 70);
            else
                len = $urandom_range(0, 12);
            send_message(len, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 5) == 0) wait_all_digests();
        end
        quiet = 1'b0;
        wait_all_digests();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
sv/sha_pkg.sv
sv/sha_msg.sv
sv/sha_core.sv
sv/sha256_hash_engine.sv
tb/sha256_digest_checker.sv
tb/tb_sha256_hash_engine.sv
